@@ hw/rtl/dss_pkg.sv @@
// Package for the dual stack shared memory block.
// Holds the store geometry, operation and status codes, controller states and
// the command and status structs between the controller and the datapath.
package dss_pkg;

  // Store geometry.
  localparam int DEPTH   = 16;
  localparam int WIDTH   = 32;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;

  // Operation codes carried by the mode field; the fourth code does nothing.
  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_PEEK = 2'd2
  } mode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic write;
    logic inc;
    logic dec;
    logic respond;
    logic use_ram;
  } dss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_push;
    logic is_read;
    logic is_pop;
    logic full;
    logic empty;
  } dss_sts_t;

endpackage

@@ hw/rtl/dual_stack_shared_memory.sv @@
// Dual stack shared memory: two LIFO stacks in one 16-word store.
// Timing: done is registered from the respond command, which the controller
// raises in the execute state for push, failed or unused operations and in the
// store read state for an ok pop or peek (registered store read). The controller
// handles one word at a time and takes no new word until idle. The receiver cannot stall.
// Reset: rst (synchronous) empties both stacks and clears done; store kept.
module dual_stack_shared_memory (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic               stack_sel,
  input  logic signed [31:0] push_value,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [31:0] read_value
);
  import dss_pkg::*;

  dss_cmd_t cmd;
  dss_sts_t sts;

  dss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  dss_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .stack_sel  (stack_sel),
    .push_value (push_value),
    .cmd        (cmd),
    .sts        (sts),
    .status     (status),
    .read_value (read_value),
    .done       (done)
  );

  // A result is only shown once the controller is back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // An accepted word keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  // A failed operation returns zero data.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (read_value == '0))
    else $error("nonzero data on failed operation");

  // A push never reaches the store once the two stacks fill it.
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> !sts.full)
    else $error("store write while full");

endmodule

@@ hw/rtl/dss_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; width and depth are set by parameters.
module dss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; contents are not reset.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/dss_datapath.sv @@
// Datapath of the dual stack shared memory: operand registers, the two stack
// counts, address generation, the shared store and the result registers.
// Depends on dss_pkg and dss_ram.
module dss_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [1:0]               mode,
  input  logic                     stack_sel,
  input  logic signed [31:0]       push_value,
  input  dss_pkg::dss_cmd_t        cmd,
  output dss_pkg::dss_sts_t        sts,
  output logic [1:0]               status,
  output logic signed [31:0]       read_value,
  output logic                     done
);
  import dss_pkg::*;

  logic [1:0]        op_mode;
  logic              op_sel;
  logic [WIDTH-1:0]  op_value;
  logic [CNT_W-1:0]  low_count;
  logic [CNT_W-1:0]  high_count;
  logic [CNT_W-1:0]  sel_count;
  logic [SUM_W-1:0]  used;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [CNT_W-1:0]  high_base;
  logic [WIDTH-1:0]  ram_rdata;
  status_t           res_status;
  status_t           status_c;

  // Operand capture when a word is accepted.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode  <= mode;
      op_sel   <= stack_sel;
      op_value <= push_value;
    end
  end

  // Fill and empty tests against the counts.
  assign used      = {1'b0, low_count} + {1'b0, high_count};
  assign sel_count = op_sel ? high_count : low_count;

  // Decode of the held operation; the unused code is neither push nor read.
  always_comb begin
    sts.is_push = 1'b0;
    sts.is_read = 1'b0;
    sts.is_pop  = 1'b0;
    sts.full    = (used == SUM_W'(DEPTH));
    sts.empty   = (sel_count == '0);
    unique case (op_mode)
      MODE_PUSH: sts.is_push = 1'b1;
      MODE_POP: begin
        sts.is_read = 1'b1;
        sts.is_pop  = 1'b1;
      end
      MODE_PEEK: sts.is_read = 1'b1;
      default: ;
    endcase
  end

  // Result status of the held operation.
  always_comb begin
    if (sts.is_push && sts.full) begin
      status_c = ST_OVERFLOW;
    end else if (sts.is_read && sts.empty) begin
      status_c = ST_UNDERFLOW;
    end else begin
      status_c = ST_OK;
    end
  end

  // Addresses: a push writes one past the top, a read takes the current top.
  assign high_base = CNT_W'(DEPTH) - high_count;
  assign waddr = op_sel ? (ADDR_W'(DEPTH - 1) - high_count[ADDR_W-1:0])
                        : low_count[ADDR_W-1:0];
  assign raddr = op_sel ? high_base[ADDR_W-1:0]
                        : ADDR_W'(low_count - CNT_W'(1));

  dss_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (waddr),
    .wdata (op_value),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // Stack counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_count  <= '0;
      high_count <= '0;
    end else if (cmd.inc) begin
      if (op_sel) high_count <= high_count + CNT_W'(1);
      else        low_count  <= low_count + CNT_W'(1);
    end else if (cmd.dec) begin
      if (op_sel) high_count <= high_count - CNT_W'(1);
      else        low_count  <= low_count - CNT_W'(1);
    end
  end

  // Status is latched while the operation executes, before counts move.
  // The store read cycle holds it.
  always_ff @(posedge clk) begin
    if (!cmd.use_ram) begin
      res_status <= status_c;
    end
  end

  // Result registers and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      read_value <= cmd.use_ram ? ram_rdata : '0;
    end
  end

  assign status = res_status;

endmodule

@@ hw/rtl/dss_ctrl.sv @@
// Controller of the dual stack shared memory: sequences accept, execute and
// store read. Depends on dss_pkg.
module dss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dss_pkg::dss_sts_t sts,
  output dss_pkg::dss_cmd_t cmd,
  output logic              busy
);
  import dss_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_push && !sts.full) begin
          cmd.write   = 1'b1;
          cmd.inc     = 1'b1;
          cmd.respond = 1'b1;
          state_next  = S_IDLE;
        end else if (sts.is_read && !sts.empty) begin
          // The store read is launched at this edge with the old count.
          cmd.dec    = sts.is_pop;
          state_next = S_READ;
        end else begin
          cmd.respond = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_READ: begin
        cmd.respond = 1'b1;
        cmd.use_ram = 1'b1;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
